FILE: rtl/core/pid_hash_slot_table_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the process slot table.
// Each macro expands to a labeled concurrent assertion, or to nothing when
// the design is built for synthesis.
// ----------------------------------------------------------------------------
`ifndef PID_HASH_SLOT_TABLE_MACROS_SVH
`define PID_HASH_SLOT_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define PHST_ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");
`define PHST_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");
`else
`define PHST_ASSERT_IMPLY(label, clk, rst, cond, prop)
`define PHST_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

FILE: rtl/core/phst_pkg.sv
// ----------------------------------------------------------------------------
// phst_pkg
// Types, constants and command codes shared by the process slot table.
// ----------------------------------------------------------------------------
package phst_pkg;
   localparam int NUM_SLOTS   = 64;
   localparam int NUM_BUCKETS = 128;
   localparam int SLOT_W      = $clog2(NUM_SLOTS);
   localparam int LINK_W      = $clog2(NUM_SLOTS + 1);
   localparam int BUCKET_W    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int PID_W       = 31;
   localparam int CFG_W       = 7;
   localparam int ADDR_W      = 1;
   localparam int STEPS_W     = $clog2(NUM_SLOTS + 1);
   localparam logic [LINK_W-1:0] NIL = LINK_W'(NUM_SLOTS);
   localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(64);
   localparam logic [ADDR_W-1:0] REG_ACTIVE_SLOTS = '0;

   typedef enum logic [2:0] {
      CMD_ALLOC = 3'd0, CMD_RELEASE = 3'd1, CMD_INSERT = 3'd2,
      CMD_REMOVE = 3'd3, CMD_LOOKUP = 3'd4, CMD_INIT = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_NO_FREE = 2'd1, ST_NOT_FOUND = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_HEAD, S_WALK_RD, S_WALK_CHK, S_REM_PID, S_INIT, S_DONE
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_LATCH, OP_ALLOC, OP_RELEASE, OP_INSERT, OP_RD_PID, OP_RD_HEAD,
      OP_RD_NODE, OP_CHECK, OP_INIT_STEP
   } op_type;

   typedef struct packed {
      op_type op;
      logic   rsp_load;
   } ctrl_type;

   typedef struct packed {
      cmd_type cmd;
      logic    slot_ok;
      logic    cur_ok;
      logic    walk_done;
      logic    init_done;
   } stat_type;

   function automatic logic [BUCKET_W-1:0] bucket_of(input logic [PID_W-1:0] p);
      return BUCKET_W'(p % NUM_BUCKETS);
   endfunction
endpackage

FILE: rtl/core/phst_if.sv
// ----------------------------------------------------------------------------
// phst_req_if / phst_rsp_if
// Valid-ready channels for commands and results of the slot table.
// ----------------------------------------------------------------------------
interface phst_req_if import phst_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [2:0]           cmd;
   logic [5:0]           slot;
   logic [PID_W-1:0]     pid;
   modport source (output valid, cmd, slot, pid, input ready);
   modport sink (input valid, cmd, slot, pid, output ready);
endinterface

interface phst_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [5:0] slot_out;
   modport source (output valid, status, slot_out, input ready);
   modport sink (input valid, status, slot_out, output ready);
endinterface

FILE: rtl/core/phst_ram.sv
// ----------------------------------------------------------------------------
// phst_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module phst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

FILE: rtl/core/phst_ctrl.sv
// ----------------------------------------------------------------------------
// phst_ctrl
// Command sequencer of the slot table: issues datapath operations per state.
// ----------------------------------------------------------------------------
`include "pid_hash_slot_table_macros.svh"
module phst_ctrl import phst_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output ctrl_type ctrl
);
   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      ctrl.op       = OP_NONE;
      ctrl.rsp_load = 1'b0;
      req_ready     = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl.op  = OP_LATCH;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.cmd)
               CMD_ALLOC: begin
                  ctrl.op  = OP_ALLOC;
                  state_in = S_DONE;
               end
               CMD_RELEASE: begin
                  ctrl.op  = OP_RELEASE;
                  state_in = S_DONE;
               end
               CMD_INSERT: begin
                  ctrl.op  = OP_RD_HEAD;
                  state_in = stat.slot_ok ? S_HEAD : S_DONE;
               end
               CMD_REMOVE: begin
                  ctrl.op  = OP_RD_PID;
                  state_in = stat.slot_ok ? S_REM_PID : S_DONE;
               end
               CMD_LOOKUP: begin
                  ctrl.op  = OP_RD_HEAD;
                  state_in = S_HEAD;
               end
               CMD_INIT: begin
                  ctrl.op  = OP_INIT_STEP;
                  state_in = S_INIT;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_REM_PID: begin
            ctrl.op  = OP_RD_HEAD;
            state_in = S_HEAD;
         end
         S_HEAD: begin
            if (stat.cmd == CMD_INSERT) begin
               ctrl.op  = OP_INSERT;
               state_in = S_DONE;
            end else begin
               ctrl.op  = OP_RD_NODE;
               state_in = S_WALK_RD;
            end
         end
         S_WALK_RD: begin
            state_in = S_WALK_CHK;
         end
         S_WALK_CHK: begin
            ctrl.op  = OP_CHECK;
            state_in = stat.walk_done ? S_DONE : S_WALK_RD;
         end
         S_INIT: begin
            ctrl.op  = OP_INIT_STEP;
            if (stat.init_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               ctrl.rsp_load = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   `PHST_ASSERT_IMPLY(a_ready_idle, clock, reset, req_ready, state_ff == S_IDLE)
   `PHST_ASSERT_NEXT(a_accept_decode, clock, reset, req_valid && req_ready, state_ff == S_DECODE)
   `PHST_ASSERT_NEXT(a_load_valid, clock, reset, ctrl.rsp_load, rsp_valid_ff)
endmodule

FILE: rtl/core/phst_dp.sv
// ----------------------------------------------------------------------------
// phst_dp
// Datapath of the slot table: memories, link registers and the result.
// Links are walked one at a time: each link's memory read is registered before it is checked.
// ----------------------------------------------------------------------------
`include "pid_hash_slot_table_macros.svh"
module phst_dp import phst_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  ctrl_type          ctrl,
   output stat_type          stat,
   input  logic [2:0]        req_cmd,
   input  logic [5:0]        req_slot,
   input  logic [PID_W-1:0]  req_pid,
   input  logic [CFG_W-1:0]  active_slots,
   output logic [1:0]        rsp_status,
   output logic [5:0]        rsp_slot_out
);
   cmd_type                cmd_ff;
   logic [LINK_W-1:0]      slot_ff;
   logic [PID_W-1:0]       pid_ff;
   logic [LINK_W-1:0]      free_head_ff, free_head_in;
   logic [LINK_W-1:0]      cur_ff, prev_ff;
   logic [STEPS_W-1:0]     steps_ff;
   logic [BUCKET_W-1:0]    bkt_ff;
   status_type             res_st_ff;
   logic [SLOT_W-1:0]      res_slot_ff;
   logic [1:0]             rsp_status_ff;
   logic [5:0]             rsp_slot_ff;
   logic [LINK_W-1:0]      init_n_ff;
   logic [NUM_BUCKETS-1:0] bvalid_ff;
   logic                   done_ff;

   logic                   fn_we, cn_we, pid_we, bh_we;
   logic [SLOT_W-1:0]      fn_addr, cn_addr, pid_addr;
   logic [BUCKET_W-1:0]    bh_addr;
   logic [LINK_W-1:0]      fn_wd, cn_wd, bh_wd, fn_rd, cn_rd, bh_rd_raw, bh_rd;
   logic [PID_W-1:0]       pid_wd, pid_rd;
   logic                   bh_valid_q;
   logic                   cur_ok;
   logic [LINK_W-1:0]      init_cap;

   phst_ram #(.WIDTH(LINK_W), .DEPTH(NUM_SLOTS)) u_free_next (
      .clock(clock), .we(fn_we), .addr(fn_addr), .wdata(fn_wd), .rdata(fn_rd));
   phst_ram #(.WIDTH(LINK_W), .DEPTH(NUM_SLOTS)) u_chain_next (
      .clock(clock), .we(cn_we), .addr(cn_addr), .wdata(cn_wd), .rdata(cn_rd));
   phst_ram #(.WIDTH(PID_W), .DEPTH(NUM_SLOTS)) u_slot_pid (
      .clock(clock), .we(pid_we), .addr(pid_addr), .wdata(pid_wd), .rdata(pid_rd));
   phst_ram #(.WIDTH(LINK_W), .DEPTH(NUM_BUCKETS)) u_bucket_head (
      .clock(clock), .we(bh_we), .addr(bh_addr), .wdata(bh_wd), .rdata(bh_rd_raw));

   assign bh_rd  = bh_valid_q ? bh_rd_raw : NIL;
   assign cur_ok = cur_ff < NIL;
   assign init_cap = (active_slots > CFG_W'(NUM_SLOTS)) ? NIL : LINK_W'(active_slots);

   assign stat.cmd       = cmd_ff;
   assign stat.slot_ok   = slot_ff < NIL;
   assign stat.cur_ok    = cur_ok;
   assign stat.walk_done = done_ff;
   assign stat.init_done = (init_cap == '0) || (init_n_ff + 1'b1 >= init_cap);

   always_comb begin
      fn_we    = 1'b0;
      fn_addr  = SLOT_W'(free_head_ff);
      fn_wd    = free_head_ff;
      cn_we    = 1'b0;
      cn_addr  = SLOT_W'(cur_ff);
      cn_wd    = bh_rd;
      pid_we   = 1'b0;
      pid_addr = SLOT_W'(cur_ff);
      pid_wd   = pid_ff;
      bh_we    = 1'b0;
      bh_addr  = bkt_ff;
      bh_wd    = slot_ff;
      free_head_in = free_head_ff;
      case (ctrl.op)
         OP_RELEASE: begin
            if (slot_ff < NIL) begin
               fn_we        = 1'b1;
               fn_addr      = SLOT_W'(slot_ff);
               free_head_in = slot_ff;
            end
         end
         OP_ALLOC: begin
            if (free_head_ff < NIL) begin
               free_head_in = fn_rd;
            end
         end
         OP_RD_PID: begin
            pid_addr = SLOT_W'(slot_ff);
         end
         OP_RD_HEAD: begin
            if (cmd_ff == CMD_REMOVE) begin
               bh_addr = bucket_of(pid_rd);
            end
         end
         OP_INSERT: begin
            pid_we   = 1'b1;
            pid_addr = SLOT_W'(slot_ff);
            cn_we    = 1'b1;
            cn_addr  = SLOT_W'(slot_ff);
            bh_we    = 1'b1;
         end
         OP_CHECK: begin
            if (cmd_ff == CMD_REMOVE && cur_ok && cur_ff == slot_ff && !done_ff) begin
               if (prev_ff == NIL) begin
                  bh_we = 1'b1;
                  bh_wd = cn_rd;
               end else begin
                  cn_we   = 1'b1;
                  cn_addr = SLOT_W'(prev_ff);
                  cn_wd   = cn_rd;
               end
            end
         end
         OP_INIT_STEP: begin
            if (init_cap != '0) begin
               fn_we   = 1'b1;
               fn_addr = SLOT_W'(init_n_ff);
               fn_wd   = (init_n_ff + 1'b1 >= init_cap) ? NIL : init_n_ff + 1'b1;
               free_head_in = '0;
            end else begin
               free_head_in = NIL;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff <= NIL;
         bvalid_ff    <= '0;
         bh_valid_q   <= 1'b0;
      end else begin
         free_head_ff <= free_head_in;
         bh_valid_q   <= bvalid_ff[bh_addr];
         if (bh_we) begin
            bvalid_ff[bh_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (ctrl.op)
         OP_LATCH: begin
            cmd_ff      <= cmd_type'(req_cmd);
            slot_ff     <= LINK_W'(req_slot);
            pid_ff      <= req_pid;
            bkt_ff      <= bucket_of(req_pid);
            res_st_ff   <= ST_OK;
            res_slot_ff <= '0;
            init_n_ff   <= '0;
            prev_ff     <= NIL;
            steps_ff    <= '0;
            done_ff     <= 1'b0;
         end
         OP_ALLOC: begin
            if (free_head_ff < NIL) begin
               res_slot_ff <= SLOT_W'(free_head_ff);
            end else begin
               res_st_ff <= ST_NO_FREE;
            end
         end
         OP_RD_HEAD: begin
            if (cmd_ff == CMD_REMOVE) begin
               bkt_ff <= bucket_of(pid_rd);
            end
         end
         OP_RD_NODE: begin
            cur_ff <= bh_rd;
            if (cmd_ff == CMD_LOOKUP) begin
               res_st_ff <= ST_NOT_FOUND;
            end
         end
         OP_CHECK: begin
            if (!cur_ok || steps_ff == STEPS_W'(NUM_SLOTS)) begin
               done_ff <= 1'b1;
            end else if (cmd_ff == CMD_LOOKUP && pid_rd == pid_ff) begin
               res_st_ff   <= ST_OK;
               res_slot_ff <= SLOT_W'(cur_ff);
               done_ff     <= 1'b1;
            end else if (cmd_ff == CMD_REMOVE && cur_ff == slot_ff) begin
               done_ff <= 1'b1;
            end else begin
               prev_ff  <= cur_ff;
               cur_ff   <= cn_rd;
               steps_ff <= steps_ff + 1'b1;
            end
         end
         OP_INIT_STEP: begin
            init_n_ff <= init_n_ff + 1'b1;
         end
         default: begin
         end
      endcase
      if (ctrl.rsp_load) begin
         rsp_status_ff <= 2'(res_st_ff);
         rsp_slot_ff   <= 6'(res_slot_ff);
      end
   end

   assign rsp_status   = rsp_status_ff;
   assign rsp_slot_out = rsp_slot_ff;

   `PHST_ASSERT_IMPLY(a_slot_out_zero, clock, reset, ctrl.rsp_load && res_st_ff != ST_OK, res_slot_ff == '0)
   `PHST_ASSERT_IMPLY(a_insert_inrange, clock, reset, pid_we, slot_ff < NIL)
   `PHST_ASSERT_IMPLY(a_one_bh_write, clock, reset, bh_we, ctrl.op == OP_INSERT || ctrl.op == OP_CHECK)
endmodule

FILE: rtl/core/pid_hash_slot_table.sv
// Alloc, release and unused commands go from decode straight to the result; insert
// adds a head step. Lookup and remove walk the chain, remove after reading the pid.
// Init writes one free link a cycle, one per active slot.
// One command is in work at a time; the next is taken once the result is loaded.
// Synchronous reset empties all buckets and the free list; active_slots is 64.
// ----------------------------------------------------------------------------
// pid_hash_slot_table
// Process slot table with a free list and a pid hash with chained slots.
// ----------------------------------------------------------------------------
module pid_hash_slot_table import phst_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   phst_req_if.sink          req,
   phst_rsp_if.source        rsp,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W+1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   logic [CFG_W-1:0] active_ff;
   ctrl_type         ctrl;
   stat_type         stat;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[ADDR_W+1:2] == REG_ACTIVE_SLOTS) ? 32'(active_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite
                   && csr_paddr[ADDR_W+1:2] == REG_ACTIVE_SLOTS) begin
         active_ff <= csr_pwdata[CFG_W-1:0];
      end
   end

   phst_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .stat(stat), .ctrl(ctrl));

   phst_dp u_dp (
      .clock(clock), .reset(reset), .ctrl(ctrl), .stat(stat), .req_cmd(req.cmd),
      .req_slot(req.slot), .req_pid(req.pid), .active_slots(active_ff),
      .rsp_status(rsp.status), .rsp_slot_out(rsp.slot_out));
endmodule
